@@ src/tlat_pkg.sv @@
// Package for the two-level address translator: sizes, function codes,
// payload structs and the table entry types. Used by every module in src.
package tlat_pkg;

  localparam int DIR_DEPTH = 256;
  localparam int PT_DEPTH  = 1024;

  localparam int DIR_AW = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1;
  localparam int PT_AW  = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
  localparam int DIR_CW = $clog2(DIR_DEPTH + 1);
  localparam int PT_CW  = $clog2(PT_DEPTH + 1);
  localparam int SCAN_W = (DIR_CW > PT_CW) ? DIR_CW : PT_CW;

  localparam int PID_W   = 16;
  localparam int IDX_W   = 10;
  localparam int ADDR_W  = 32;
  localparam int FRAME_W = 20;
  localparam int OFF_W   = 12;

  // Virtual address split: directory index, table index, page offset.
  localparam int VA_DI_LSB = 22;
  localparam int VA_TI_LSB = 12;

  localparam logic [1:0] FUNC_LOAD_DIR  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_PT   = 2'd1;
  localparam logic [1:0] FUNC_TRANSLATE = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [PID_W-1:0]  pid;
    logic [IDX_W-1:0]  dir_index;
    logic              entry_valid;
    logic [ADDR_W-1:0] table_addr;
    logic [IDX_W-1:0]  pt_index;
    logic [ADDR_W-1:0] frame_addr;
    logic [ADDR_W-1:0] virt_addr;
  } tlat_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] phys_addr;
    logic              mapped;
  } tlat_out_t;

  // Search key as seen by the shared compare unit.
  typedef struct packed {
    logic              valid;
    logic [PID_W-1:0]  pid;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] tbl;
  } tlat_key_t;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [IDX_W-1:0]  idx;
    logic              valid;
    logic [ADDR_W-1:0] tbl;
  } tlat_dir_ent_t;

  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [ADDR_W-1:0]  tbl;
    logic [IDX_W-1:0]   idx;
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } tlat_pt_ent_t;

  // Write and read strobes from the sequencer to the table store.
  typedef struct packed {
    logic dir_we;
    logic dir_re;
    logic pt_we;
    logic pt_re;
  } tlat_mem_ctl_t;

endpackage

@@ src/two_level_address_translator_unit.sv @@
// Two-level address translator: a load word gives no result. A translate word
// scans the directory and then, when a page-table address is found, the page
// table, one entry per cycle through a single compare unit. Reset (rst_n,
// synchronous) empties both tables by clearing the counts.
// Depends on tlat_pkg, tlat_store and tlat_cmp.
module two_level_address_translator_unit
  import tlat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tlat_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output tlat_out_t out_data
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIR  = 2'd1;
  localparam logic [1:0] S_PT   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [DIR_CW-1:0] dir_cnt_r, dir_cnt_nxt;
  logic [PT_CW-1:0]  pt_cnt_r, pt_cnt_nxt;
  logic [SCAN_W-1:0] scan_r, scan_nxt;
  logic              chk_r, chk_nxt;
  logic [PID_W-1:0]  pid_r, pid_nxt;
  logic [ADDR_W-1:0] va_r, va_nxt;
  logic [ADDR_W-1:0] tbl_r, tbl_nxt;
  tlat_out_t         res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  tlat_out_t         out_data_r, out_data_nxt;

  tlat_mem_ctl_t     ctl;
  tlat_dir_ent_t     dir_wdata, dir_rdata;
  tlat_pt_ent_t      pt_wdata, pt_rdata;
  tlat_key_t         cmp_ent, cmp_req;
  logic              cmp_hit;
  logic              in_pt;

  // Table storage. Loads write at the fill count; scans read at scan_r.
  tlat_store u_store (
    .clk       (clk),
    .ctl       (ctl),
    .dir_waddr (dir_cnt_r[DIR_AW-1:0]),
    .dir_wdata (dir_wdata),
    .dir_raddr (scan_r[DIR_AW-1:0]),
    .dir_rdata (dir_rdata),
    .pt_waddr  (pt_cnt_r[PT_AW-1:0]),
    .pt_wdata  (pt_wdata),
    .pt_raddr  (scan_r[PT_AW-1:0]),
    .pt_rdata  (pt_rdata)
  );

  assign dir_wdata = '{pid:   in_data.pid,
                       idx:   in_data.dir_index,
                       valid: in_data.entry_valid,
                       tbl:   in_data.table_addr};

  // Only the upper 20 bits of the frame address are kept.
  assign pt_wdata = '{pid:   in_data.pid,
                      tbl:   in_data.table_addr,
                      idx:   in_data.pt_index,
                      valid: in_data.entry_valid,
                      frame: in_data.frame_addr[ADDR_W-1:OFF_W]};

  // The one compare unit sees the directory entry during the first scan and
  // the page-table entry during the second.
  assign in_pt = (state_r == S_PT);

  always_comb begin
    if (in_pt) begin
      cmp_ent = '{valid: pt_rdata.valid, pid: pt_rdata.pid,
                  idx: pt_rdata.idx, tbl: pt_rdata.tbl};
      cmp_req = '{valid: 1'b1, pid: pid_r,
                  idx: va_r[VA_TI_LSB +: IDX_W], tbl: tbl_r};
    end else begin
      cmp_ent = '{valid: dir_rdata.valid, pid: dir_rdata.pid,
                  idx: dir_rdata.idx, tbl: dir_rdata.tbl};
      cmp_req = '{valid: 1'b1, pid: pid_r,
                  idx: va_r[VA_DI_LSB +: IDX_W], tbl: '0};
    end
  end

  tlat_cmp u_cmp (
    .ent     (cmp_ent),
    .req     (cmp_req),
    .use_tbl (in_pt),
    .hit     (cmp_hit)
  );

  // Sequencer. During a scan one read is issued per cycle; chk_r marks that
  // the read data belongs to the entry issued the cycle before, so a hit on
  // it stops the scan before the next entry is looked at.
  always_comb begin
    state_nxt     = state_r;
    dir_cnt_nxt   = dir_cnt_r;
    pt_cnt_nxt    = pt_cnt_r;
    scan_nxt      = scan_r;
    chk_nxt       = chk_r;
    pid_nxt       = pid_r;
    va_nxt        = va_r;
    tbl_nxt       = tbl_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ctl           = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.func)
            FUNC_LOAD_DIR: begin
              // A load into a full table is dropped.
              if (dir_cnt_r != DIR_CW'(DIR_DEPTH)) begin
                ctl.dir_we  = 1'b1;
                dir_cnt_nxt = dir_cnt_r + 1'b1;
              end
            end
            FUNC_LOAD_PT: begin
              if (pt_cnt_r != PT_CW'(PT_DEPTH)) begin
                ctl.pt_we  = 1'b1;
                pt_cnt_nxt = pt_cnt_r + 1'b1;
              end
            end
            FUNC_TRANSLATE: begin
              pid_nxt   = in_data.pid;
              va_nxt    = in_data.virt_addr;
              scan_nxt  = '0;
              chk_nxt   = 1'b0;
              state_nxt = S_DIR;
            end
            default: begin
              // The unused function code is taken and ignored.
            end
          endcase
        end
      end
      S_DIR: begin
        if (chk_r && cmp_hit) begin
          // The first matching entry decides; a zero address means unmapped.
          if (dir_rdata.tbl == '0) begin
            res_nxt   = '0;
            state_nxt = S_OUT;
          end else begin
            tbl_nxt   = dir_rdata.tbl;
            scan_nxt  = '0;
            chk_nxt   = 1'b0;
            state_nxt = S_PT;
          end
        end else if (scan_r == SCAN_W'(dir_cnt_r)) begin
          res_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          ctl.dir_re = 1'b1;
          scan_nxt   = scan_r + 1'b1;
          chk_nxt    = 1'b1;
        end
      end
      S_PT: begin
        if (chk_r && cmp_hit) begin
          res_nxt   = '{phys_addr: {pt_rdata.frame, va_r[OFF_W-1:0]}, mapped: 1'b1};
          state_nxt = S_OUT;
        end else if (scan_r == SCAN_W'(pt_cnt_r)) begin
          res_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          ctl.pt_re = 1'b1;
          scan_nxt  = scan_r + 1'b1;
          chk_nxt   = 1'b1;
        end
      end
      S_OUT: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dir_cnt_r   <= '0;
      pt_cnt_r    <= '0;
      scan_r      <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dir_cnt_r   <= dir_cnt_nxt;
      pt_cnt_r    <= pt_cnt_nxt;
      scan_r      <= scan_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload registers carry no reset.
  always_ff @(posedge clk) begin
    pid_r      <= pid_nxt;
    va_r       <= va_nxt;
    tbl_r      <= tbl_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Loads are taken only while the sequencer is idle: a result held in the output
  // register does not block them, but one waiting in S_OUT for that register does.
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_dir_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dir_cnt_r <= DIR_CW'(DIR_DEPTH))
    else $error("directory fill count above depth");

  a_pt_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pt_cnt_r <= PT_CW'(PT_DEPTH))
    else $error("page-table fill count above depth");

  a_dir_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIR) |-> (scan_r <= SCAN_W'(dir_cnt_r)))
    else $error("directory scan ran past the filled entries");

  a_cnt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> ($stable(dir_cnt_r) && $stable(pt_cnt_r)))
    else $error("table filled during a translation");

  a_translate_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.func == FUNC_TRANSLATE)) |=> (state_r == S_DIR))
    else $error("translate word did not start a directory scan");

endmodule

@@ src/tlat_store.sv @@
// Directory and page-table storage, one write and one registered read port each.
// Depends on tlat_pkg for the depths and entry types.
module tlat_store
  import tlat_pkg::*;
(
  input  logic          clk,
  input  tlat_mem_ctl_t ctl,
  input  logic [DIR_AW-1:0] dir_waddr,
  input  tlat_dir_ent_t dir_wdata,
  input  logic [DIR_AW-1:0] dir_raddr,
  output tlat_dir_ent_t dir_rdata,
  input  logic [PT_AW-1:0]  pt_waddr,
  input  tlat_pt_ent_t  pt_wdata,
  input  logic [PT_AW-1:0]  pt_raddr,
  output tlat_pt_ent_t  pt_rdata
);

  tlat_dir_ent_t dir_mem [DIR_DEPTH];
  tlat_pt_ent_t  pt_mem  [PT_DEPTH];
  tlat_dir_ent_t dir_rdata_r;
  tlat_pt_ent_t  pt_rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (ctl.dir_re) begin
      dir_rdata_r <= dir_mem[dir_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    if (ctl.pt_re) begin
      pt_rdata_r <= pt_mem[pt_raddr];
    end
  end

  assign dir_rdata = dir_rdata_r;
  assign pt_rdata  = pt_rdata_r;

endmodule

@@ src/tlat_cmp.sv @@
// Shared key compare unit used by both the directory and the page-table scan.
// Depends on tlat_pkg for the key type.
module tlat_cmp
  import tlat_pkg::*;
(
  input  tlat_key_t ent,
  input  tlat_key_t req,
  input  logic      use_tbl,
  output logic      hit
);

  // The table address only takes part in the page-table search.
  assign hit = req.valid && ent.valid && (ent.pid == req.pid) && (ent.idx == req.idx) &&
               (!use_tbl || (ent.tbl == req.tbl));

endmodule

@@ dv/tlat_xlate_checker.sv @@
`timescale 1ns / 1ps
// Checker for the two-level address translator: keeps its own copy of both
// tables from the accepted load words, predicts each translation and compares
// result words in order. Depends on tlat_pkg.
module tlat_xlate_checker
  import tlat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  tlat_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  tlat_out_t out_data,
  output int        err_count,
  output int        phys_in_flight,
  output int        mapped_count
);

  tlat_dir_ent_t dir_tab [DIR_DEPTH];
  tlat_pt_ent_t  pt_tab  [PT_DEPTH];
  int            dir_fill = 0;
  int            pt_fill = 0;
  int            errs = 0;
  int            hits = 0;
  int            in_flight = 0;
  tlat_out_t     phys_q [$];

  assign err_count      = errs;
  assign phys_in_flight = in_flight;
  assign mapped_count   = hits;

  // First valid match wins in both tables; a zero page-table address ends the walk.
  function automatic tlat_out_t lookup_phys(input logic [PID_W-1:0] pid,
                                            input logic [ADDR_W-1:0] va);
    logic [IDX_W-1:0]  di;
    logic [IDX_W-1:0]  ti;
    logic [ADDR_W-1:0] tbl;
    tlat_out_t         res;
    tlat_dir_ent_t     de;
    tlat_pt_ent_t      pe;
    di  = va[VA_DI_LSB +: IDX_W];
    ti  = va[VA_TI_LSB +: IDX_W];
    tbl = '0;
    res = '0;
    for (int i = 0; i < dir_fill; i++) begin
      de = dir_tab[DIR_AW'(i)];
      if (de.valid && de.pid == pid && de.idx == di) begin
        tbl = de.tbl;
        break;
      end
    end
    if (tbl != '0) begin
      for (int i = 0; i < pt_fill; i++) begin
        pe = pt_tab[PT_AW'(i)];
        if (pe.valid && pe.pid == pid && pe.tbl == tbl && pe.idx == ti) begin
          res.phys_addr = {pe.frame, va[OFF_W-1:0]};
          res.mapped    = 1'b1;
          break;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    tlat_out_t         want;
    logic [DIR_AW-1:0] dslot;
    logic [PT_AW-1:0]  pslot;
    if (!rst_n) begin
      dir_fill = 0;
      pt_fill  = 0;
      phys_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        case (in_data.func)
          FUNC_LOAD_DIR: begin
            if (dir_fill < DIR_DEPTH) begin
              dslot                = DIR_AW'(dir_fill);
              dir_tab[dslot].pid   = in_data.pid;
              dir_tab[dslot].idx   = in_data.dir_index;
              dir_tab[dslot].valid = in_data.entry_valid;
              dir_tab[dslot].tbl   = in_data.table_addr;
              dir_fill++;
            end
          end
          FUNC_LOAD_PT: begin
            if (pt_fill < PT_DEPTH) begin
              pslot               = PT_AW'(pt_fill);
              pt_tab[pslot].pid   = in_data.pid;
              pt_tab[pslot].tbl   = in_data.table_addr;
              pt_tab[pslot].idx   = in_data.pt_index;
              pt_tab[pslot].valid = in_data.entry_valid;
              pt_tab[pslot].frame = in_data.frame_addr[ADDR_W-1 -: FRAME_W];
              pt_fill++;
            end
          end
          FUNC_TRANSLATE: phys_q.push_back(lookup_phys(in_data.pid, in_data.virt_addr));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (phys_q.size() == 0) begin
          $error("unexpected result word: phys_addr %h mapped %b",
                 out_data.phys_addr, out_data.mapped);
          errs++;
        end else begin
          want = phys_q.pop_front();
          if (out_data.phys_addr !== want.phys_addr) begin
            $error("phys_addr: expected %h, actual %h", want.phys_addr, out_data.phys_addr);
            errs++;
          end
          if (out_data.mapped !== want.mapped) begin
            $error("mapped: expected %b, actual %b", want.mapped, out_data.mapped);
            errs++;
          end
          if (want.mapped) hits++;
        end
      end
    end
    in_flight = phys_q.size();
  end

endmodule

@@ dv/tb_two_level_address_translator_unit.sv @@
`timescale 1ns / 1ps
// Testbench top for two_level_address_translator_unit: makes load and translate
// words with random gaps and result stalls, then reports the checker's verdict.
// Depends on tlat_pkg, the translator RTL and tlat_xlate_checker.
module tb_two_level_address_translator_unit;
  import tlat_pkg::*;

  // A word with this function code must be swallowed without a result.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // The longest legal quiet stretch is one translation over two full tables plus a
  // long sender gap and a long result stall. The watchdog allows several times that.
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 1300;
  localparam int RANDOM_ITEMS   = 230;

  // One mapping the stimulus has loaded and may walk again later.
  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [IDX_W-1:0]  di;
    logic [ADDR_W-1:0] tbl;
    logic [IDX_W-1:0]  ti;
  } route_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  tlat_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  tlat_out_t out_data;

  int err_count;
  int phys_in_flight;
  int mapped_count;

  // While quiet is set neither side idles, so back-to-back words get exercised.
  bit quiet = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;
  int item_cnt = 0;
  int dir_sent = 0;
  int pt_sent = 0;
  int xlate_sent = 0;
  int ignored_sent = 0;
  route_t routes [$];

  two_level_address_translator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  tlat_xlate_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .err_count      (err_count),
    .phys_in_flight (phys_in_flight),
    .mapped_count   (mapped_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Idle lengths: mostly short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Fields a function does not use still carry random bits, so every bit of
  // every field toggles even where the block ignores it.
  function automatic tlat_in_t rand_word();
    tlat_in_t w;
    w.func        = 2'($urandom_range(0, 3));
    w.pid         = PID_W'($urandom);
    w.dir_index   = IDX_W'($urandom);
    w.entry_valid = 1'($urandom);
    w.table_addr  = $urandom;
    w.pt_index    = IDX_W'($urandom);
    w.frame_addr  = $urandom;
    w.virt_addr   = $urandom;
    return w;
  endfunction

  function automatic tlat_in_t mk_dir(input logic [PID_W-1:0] pid, input logic [IDX_W-1:0] di,
                                      input logic vld, input logic [ADDR_W-1:0] tbl);
    tlat_in_t w;
    w             = rand_word();
    w.func        = FUNC_LOAD_DIR;
    w.pid         = pid;
    w.dir_index   = di;
    w.entry_valid = vld;
    w.table_addr  = tbl;
    return w;
  endfunction

  function automatic tlat_in_t mk_pt(input logic [PID_W-1:0] pid, input logic [ADDR_W-1:0] tbl,
                                     input logic [IDX_W-1:0] ti, input logic vld,
                                     input logic [ADDR_W-1:0] frame);
    tlat_in_t w;
    w             = rand_word();
    w.func        = FUNC_LOAD_PT;
    w.pid         = pid;
    w.table_addr  = tbl;
    w.pt_index    = ti;
    w.entry_valid = vld;
    w.frame_addr  = frame;
    return w;
  endfunction

  function automatic tlat_in_t mk_xlate(input logic [PID_W-1:0] pid,
                                        input logic [ADDR_W-1:0] va);
    tlat_in_t w;
    w           = rand_word();
    w.func      = FUNC_TRANSLATE;
    w.pid       = pid;
    w.virt_addr = va;
    return w;
  endfunction

  // Presents one word at a falling edge and returns at the rising edge that
  // accepts it. Valid is only dropped when a gap is inserted, and then it is
  // raised again at a later falling edge, never in the same time step.
  task automatic send_word(input tlat_in_t w);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 45) gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (w.func)
      FUNC_LOAD_DIR:  dir_sent++;
      FUNC_LOAD_PT:   pt_sent++;
      FUNC_TRANSLATE: xlate_sent++;
      default:        ignored_sent++;
    endcase
    if (w.func != FUNC_UNUSED) item_cnt++;
  endtask

  // Drops valid and holds off until the checker has seen every result come back.
  task automatic drain_wait();
    @(negedge clk);
    in_valid <= 1'b0;
    while (phys_in_flight != 0) @(negedge clk);
  endtask

  // A fresh well-formed walk: directory entry, page-table entry, then a
  // translation through both. Tables are sometimes shared between pids.
  task automatic new_route();
    route_t            r;
    logic [OFF_W-1:0]  off;
    logic [ADDR_W-1:0] frame;
    bit                dir_live;
    bit                pt_live;
    r.pid = PID_W'($urandom);
    if ($urandom_range(0, 3) != 0) r.pid = PID_W'($urandom_range(0, 7));
    r.di = IDX_W'($urandom);
    r.ti = IDX_W'($urandom);
    if (routes.size() > 0 && $urandom_range(0, 1) == 1) begin
      r.tbl = routes[$urandom_range(0, routes.size() - 1)].tbl;
    end else begin
      r.tbl = $urandom;
      if (r.tbl == '0) r.tbl = ADDR_W'(1);
    end
    dir_live = ($urandom_range(0, 9) != 0);
    pt_live  = ($urandom_range(0, 9) != 0);
    frame    = $urandom;
    off      = OFF_W'($urandom);
    send_word(mk_dir(r.pid, r.di, dir_live, r.tbl));
    send_word(mk_pt(r.pid, r.tbl, r.ti, pt_live, frame));
    send_word(mk_xlate(r.pid, {r.di, r.ti, off}));
    if (dir_live && pt_live) routes.push_back(r);
  endtask

  // Walks a known mapping again, sometimes through a new sibling page-table
  // entry, sometimes with one key field bent so that the walk misses.
  task automatic reuse_route();
    route_t           r;
    logic [OFF_W-1:0] off;
    int               pick;
    r    = routes[$urandom_range(0, routes.size() - 1)];
    pick = $urandom_range(0, 9);
    off  = OFF_W'($urandom);
    if (pick < 2) begin
      r.ti = IDX_W'($urandom);
      send_word(mk_pt(r.pid, r.tbl, r.ti, 1'b1, $urandom));
      routes.push_back(r);
    end else if (pick == 2) begin
      r.ti = IDX_W'($urandom);
    end else if (pick == 3) begin
      r.pid = r.pid + 1'b1;
    end else if (pick == 4) begin
      r.di = IDX_W'($urandom);
    end
    send_word(mk_xlate(r.pid, {r.di, r.ti, off}));
  endtask

  // Result side: ready is lowered for stalls of random length, except in quiet stretches.
  always @(negedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 25) begin
      out_ready  <= 1'b0;
      stall_left <= idle_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: any cycle without a handshake on either channel counts toward the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    tlat_in_t         w;
    route_t           tail;
    route_t           lost;
    logic [OFF_W-1:0] off;
    logic [PID_W-1:0] pid;
    int               goal;
    int               sel;
    bit               paused;
    paused = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A walk over empty tables must come back unmapped.
    send_word(mk_xlate(16'h0000, 32'h0000_0000));
    // All-ones keys and frame: the widest possible hit.
    send_word(mk_dir(16'hFFFF, 10'h3FF, 1'b1, 32'hFFFF_FFFF));
    send_word(mk_pt(16'hFFFF, 32'hFFFF_FFFF, 10'h3FF, 1'b1, 32'hFFFF_FFFF));
    send_word(mk_xlate(16'hFFFF, 32'hFFFF_FFFF));
    // A later duplicate page-table entry is shadowed by the first one.
    send_word(mk_pt(16'hFFFF, 32'hFFFF_FFFF, 10'h3FF, 1'b1, 32'h1234_5000));
    send_word(mk_xlate(16'hFFFF, 32'hFFFF_F000));
    // Same address under another pid misses.
    send_word(mk_xlate(16'hFFFE, 32'hFFFF_FFFF));
    // Invalid entries are stored but skipped; the hit lands on frame zero
    // with offset zero, so the physical address is zero yet mapped.
    send_word(mk_dir(16'h0001, 10'h000, 1'b0, 32'h0000_1000));
    send_word(mk_dir(16'h0001, 10'h000, 1'b1, 32'h0000_2000));
    send_word(mk_pt(16'h0001, 32'h0000_2000, 10'h000, 1'b0, 32'h0000_5000));
    send_word(mk_pt(16'h0001, 32'h0000_1000, 10'h000, 1'b1, 32'h0000_6000));
    send_word(mk_pt(16'h0001, 32'h0000_2000, 10'h000, 1'b1, 32'h0000_0FFF));
    send_word(mk_xlate(16'h0001, 32'h0000_0000));
    // A matching directory entry with a zero table address ends the walk,
    // even though a usable entry follows it.
    send_word(mk_dir(16'h0002, 10'h005, 1'b1, 32'h0000_0000));
    send_word(mk_dir(16'h0002, 10'h005, 1'b1, 32'h0000_3000));
    send_word(mk_pt(16'h0002, 32'h0000_3000, 10'h007, 1'b1, 32'hABCD_E123));
    send_word(mk_xlate(16'h0002, {10'h005, 10'h007, 12'h123}));
    // The unused function code must leave the tables alone and give no result.
    w      = rand_word();
    w.func = FUNC_UNUSED;
    send_word(w);
    send_word(mk_xlate(16'h0002, {10'h005, 10'h007, 12'h123}));
    send_word(mk_xlate(16'h0001, 32'h0000_0ABC));
    // A page-table entry under the wrong pid does not match.
    send_word(mk_pt(16'h0003, 32'h0000_2000, 10'h001, 1'b1, 32'h7777_7000));
    send_word(mk_xlate(16'h0001, {10'h000, 10'h001, 12'h000}));

    // Random part: mostly well-formed walks, the rest noise and broken keys.
    goal = item_cnt + RANDOM_ITEMS;
    while (item_cnt < goal) begin
      quiet = (((item_cnt / 40) % 5) == 4);
      if (!paused && item_cnt >= goal - RANDOM_ITEMS / 2) begin
        drain_wait();
        paused = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 30 || routes.size() == 0) begin
        new_route();
      end else if (sel < 55) begin
        reuse_route();
      end else if (sel < 68) begin
        pid = PID_W'($urandom);
        if ($urandom_range(0, 1) == 1) pid = PID_W'($urandom_range(0, 7));
        send_word(mk_xlate(pid, $urandom));
      end else if (sel < 78) begin
        w      = rand_word();
        w.func = FUNC_LOAD_DIR;
        if ($urandom_range(0, 3) == 0) w.table_addr = '0;
        if ($urandom_range(0, 1) == 1) w.pid = PID_W'($urandom_range(0, 7));
        send_word(w);
      end else if (sel < 88) begin
        w      = rand_word();
        w.func = FUNC_LOAD_PT;
        if ($urandom_range(0, 1) == 1) w.pid = PID_W'($urandom_range(0, 7));
        send_word(w);
      end else if (sel < 93) begin
        w      = rand_word();
        w.func = FUNC_UNUSED;
        send_word(w);
      end else begin
        reuse_route();
      end
    end

    // Capacity: fill the directory up to its last slot with random entries
    // and put a live mapping in that last slot. Directory loads past capacity
    // must be dropped, so the walk through the lost entry misses.
    quiet    = 1'b0;
    tail.pid = PID_W'($urandom);
    tail.di  = IDX_W'($urandom);
    tail.ti  = IDX_W'($urandom);
    tail.tbl = $urandom;
    if (tail.tbl == '0) tail.tbl = ADDR_W'(1);
    while (dir_sent < DIR_DEPTH - 1) begin
      w      = rand_word();
      w.func = FUNC_LOAD_DIR;
      send_word(w);
    end
    send_word(mk_dir(tail.pid, tail.di, 1'b1, tail.tbl));
    send_word(mk_pt(tail.pid, tail.tbl, tail.ti, 1'b1, $urandom));
    lost.pid = PID_W'($urandom);
    lost.di  = IDX_W'($urandom);
    lost.tbl = tail.tbl;
    lost.ti  = tail.ti ^ 10'h001;
    repeat (2) begin
      send_word(mk_dir(lost.pid, lost.di, 1'b1, lost.tbl));
      send_word(mk_pt(lost.pid, lost.tbl, lost.ti, 1'b1, $urandom));
    end
    off = OFF_W'($urandom);
    send_word(mk_xlate(tail.pid, {tail.di, tail.ti, off}));
    send_word(mk_xlate(tail.pid, {tail.di, lost.ti, off}));
    send_word(mk_xlate(lost.pid, {lost.di, lost.ti, off}));
    repeat (6) reuse_route();
    repeat (2) send_word(mk_xlate(PID_W'($urandom), $urandom));

    // Let every result come back, then keep watching for stray result words.
    drain_wait();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d directory loads, %0d page-table loads, %0d unused-code words,",
             dir_sent, pt_sent, ignored_sent);
    $display("and %0d translations (%0d mapped), with the directory pushed past capacity.",
             xlate_sent, mapped_count);
    if (err_count == 0 && phys_in_flight == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ two_level_address_translator_unit.f @@
src/tlat_pkg.sv
src/tlat_store.sv
src/tlat_cmp.sv
src/two_level_address_translator_unit.sv
dv/tlat_xlate_checker.sv
dv/tb_two_level_address_translator_unit.sv
